// ===== rtl/pdc_pkg.sv =====
// Package for the Porter-Duff RGBA8 compositor: rule codes, constants,
// the divide-by-255 helper and the structs shared between the modules.
// Depends on nothing.
`default_nettype none

package pdc_pkg;

    typedef enum logic [3:0] {
        RULE_BYPASS    = 4'd0,
        RULE_CLEAR     = 4'd1,
        RULE_COPY      = 4'd2,
        RULE_DEST      = 4'd3,
        RULE_SRC_OVER  = 4'd4,
        RULE_DEST_OVER = 4'd5,
        RULE_SRC_IN    = 4'd6,
        RULE_DEST_IN   = 4'd7,
        RULE_SRC_OUT   = 4'd8,
        RULE_DEST_OUT  = 4'd9,
        RULE_SRC_ATOP  = 4'd10,
        RULE_DEST_ATOP = 4'd11,
        RULE_XOR       = 4'd12,
        RULE_LIGHTER   = 4'd13
    } rule_t;

    localparam rule_t       RULE_RESET  = RULE_SRC_OVER;
    localparam logic [15:0] MAGIC_MUL   = 16'h8081;
    localparam int          MAGIC_SHIFT = 23;
    localparam logic [7:0]  FULL        = 8'd255;

    // Blend factors of one rule for one pixel pair.
    typedef struct packed {
        logic [7:0] fa;
        logic [7:0] fb;
        logic       bypass;
    } factor_t;

    // Load enables of the four pipeline stages.
    typedef struct packed {
        logic st1;
        logic st2;
        logic st3;
        logic st4;
    } pipe_en_t;

    // Approximate divide by 255: (x * 0x8081) >> 23, nine bits of result.
    function automatic logic [8:0] div255(input logic [15:0] x);
        logic [31:0] p;
        p = 32'(x) * 32'(MAGIC_MUL);
        return p[MAGIC_SHIFT+8:MAGIC_SHIFT];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pdc_factor.sv =====
// Rule decoder of the compositor: turns the rule code and the two alphas
// into the factors Fa and Fb and the bypass flag. Depends on pdc_pkg.
`default_nettype none

module pdc_factor (
    input  wire pdc_pkg::rule_t   rule,
    input  wire logic [7:0]       src_alpha,
    input  wire logic [7:0]       dst_alpha,
    output pdc_pkg::factor_t      factor
);

    logic [7:0] inv_sa;
    logic [7:0] inv_da;

    assign inv_sa = pdc_pkg::FULL - src_alpha;
    assign inv_da = pdc_pkg::FULL - dst_alpha;

    always_comb begin
        factor = '0;
        unique case (rule)
            pdc_pkg::RULE_BYPASS: begin
                factor.bypass = 1'b1;
            end
            pdc_pkg::RULE_CLEAR: begin
                factor = '0;
            end
            pdc_pkg::RULE_COPY: begin
                factor.fa = pdc_pkg::FULL;
            end
            pdc_pkg::RULE_DEST: begin
                factor.fb = pdc_pkg::FULL;
            end
            pdc_pkg::RULE_SRC_OVER: begin
                factor.fa = pdc_pkg::FULL;
                factor.fb = inv_sa;
            end
            pdc_pkg::RULE_DEST_OVER: begin
                factor.fa = inv_da;
                factor.fb = pdc_pkg::FULL;
            end
            pdc_pkg::RULE_SRC_IN: begin
                factor.fa = dst_alpha;
            end
            pdc_pkg::RULE_DEST_IN: begin
                factor.fb = src_alpha;
            end
            pdc_pkg::RULE_SRC_OUT: begin
                factor.fa = inv_da;
            end
            pdc_pkg::RULE_DEST_OUT: begin
                factor.fb = inv_sa;
            end
            pdc_pkg::RULE_SRC_ATOP: begin
                factor.fa = dst_alpha;
                factor.fb = inv_sa;
            end
            pdc_pkg::RULE_DEST_ATOP: begin
                factor.fa = inv_da;
                factor.fb = src_alpha;
            end
            pdc_pkg::RULE_XOR: begin
                factor.fa = inv_da;
                factor.fb = inv_sa;
            end
            pdc_pkg::RULE_LIGHTER: begin
                factor.fa = pdc_pkg::FULL;
                factor.fb = pdc_pkg::FULL;
            end
            default: begin
                // Codes without a rule act as clear.
                factor = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/pdc_lane.sv =====
// One channel lane of the compositor: premultiply, blend, saturate and
// divide, in four register stages. Depends on pdc_pkg.
`default_nettype none

module pdc_lane (
    input  wire logic               aclk,
    input  wire pdc_pkg::pipe_en_t  en,
    input  wire logic [7:0]         src_color,
    input  wire logic [7:0]         src_alpha,
    input  wire logic [7:0]         dst_color,
    input  wire logic [7:0]         dst_alpha,
    input  wire logic [7:0]         fa,
    input  wire logic [7:0]         fb,
    input  wire logic               bypass,
    input  wire logic [7:0]         bypass_value,
    output logic [7:0]              result
);

    logic [15:0] prod_s_reg, prod_d_reg;
    logic [7:0]  ps_reg, pd_reg;
    logic [15:0] sum_reg, sum_next;
    logic [16:0] sum_wide;
    logic [8:0]  quot;
    logic [7:0]  result_reg, result_next;
    logic [8:0]  ps_full, pd_full;

    assign ps_full  = pdc_pkg::div255(prod_s_reg);
    assign pd_full  = pdc_pkg::div255(prod_d_reg);
    assign sum_wide = 17'({8'd0, fa} * {8'd0, ps_reg}) + 17'({8'd0, fb} * {8'd0, pd_reg});
    assign sum_next = sum_wide[16] ? 16'hFFFF : sum_wide[15:0];
    assign quot     = pdc_pkg::div255(sum_reg);

    always_comb begin
        if (bypass) begin
            result_next = bypass_value;
        end else if (quot[8]) begin
            result_next = pdc_pkg::FULL;
        end else begin
            result_next = quot[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.st1) begin
            prod_s_reg <= {8'd0, src_color} * {8'd0, src_alpha};
            prod_d_reg <= {8'd0, dst_color} * {8'd0, dst_alpha};
        end
        if (en.st2) begin
            ps_reg <= ps_full[7:0];
            pd_reg <= pd_full[7:0];
        end
        if (en.st3) begin
            sum_reg <= sum_next;
        end
        if (en.st4) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== rtl/porter_duff_rgba8_compositor_core.sv =====
// Porter-Duff RGBA8 compositor, top level. An accepted input word passes the
// four lane register stages to the result word on the m_ side; throughput is
// one word per cycle while m_ready holds, as the lanes share no unit.
// Reset (aresetn low, synchronous) empties the pipeline and sets the rule
// register to src_over. Depends on pdc_pkg, pdc_factor and pdc_lane.
`default_nettype none

module porter_duff_rgba8_compositor_core (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       cfg_we,
    input  wire logic [3:0] cfg_wdata,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_src_red,
    input  wire logic [7:0] s_src_green,
    input  wire logic [7:0] s_src_blue,
    input  wire logic [7:0] s_src_alpha,
    input  wire logic [7:0] s_dst_red,
    input  wire logic [7:0] s_dst_green,
    input  wire logic [7:0] s_dst_blue,
    input  wire logic [7:0] s_dst_alpha,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_red,
    output logic [7:0]      m_out_green,
    output logic [7:0]      m_out_blue,
    output logic [7:0]      m_out_alpha
);

    // The rule register. The user must write it only while the pipeline is empty,
    // so the decode in stage one may read it directly. The block does not enforce this.
    pdc_pkg::rule_t rule_reg, rule_next;

    assign rule_next = cfg_we ? pdc_pkg::rule_t'(cfg_wdata) : rule_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rule_reg <= pdc_pkg::RULE_RESET;
        end else begin
            rule_reg <= rule_next;
        end
    end

    // Pipeline control. Each stage holds a valid bit; a stage loads when it
    // is empty or when the stage after it loads too, so a stall at the
    // output backs up one stage at a time and nothing is dropped or
    // repeated. The last stage is the output register, so while a finished
    // result waits for m_ready, a new word is taken if an earlier stage is empty.
    logic [3:0]         vld_reg, vld_next;
    pdc_pkg::pipe_en_t  en;

    assign en.st4  = !vld_reg[3] || m_ready;
    assign en.st3  = !vld_reg[2] || en.st4;
    assign en.st2  = !vld_reg[1] || en.st3;
    assign en.st1  = !vld_reg[0] || en.st2;
    assign s_ready = en.st1;

    always_comb begin
        vld_next[0] = en.st1 ? s_valid    : vld_reg[0];
        vld_next[1] = en.st2 ? vld_reg[0] : vld_reg[1];
        vld_next[2] = en.st3 ? vld_reg[1] : vld_reg[2];
        vld_next[3] = en.st4 ? vld_reg[2] : vld_reg[3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign m_valid = vld_reg[3];

    // Stage one decodes the rule into the two blend factors. The factors
    // are needed by the blend in stage three, so they ride along two
    // stages; the source pixel rides along three stages for bypass.
    pdc_pkg::factor_t factor;

    pdc_factor u_factor (
        .rule      (rule_reg),
        .src_alpha (s_src_alpha),
        .dst_alpha (s_dst_alpha),
        .factor    (factor)
    );

    pdc_pkg::factor_t factor_s1_reg, factor_s2_reg, factor_s3_reg;
    logic [31:0]      src_s1_reg, src_s2_reg, src_s3_reg;

    always_ff @(posedge aclk) begin
        if (en.st1) begin
            factor_s1_reg <= factor;
            src_s1_reg    <= {s_src_alpha, s_src_blue, s_src_green, s_src_red};
        end
        if (en.st2) begin
            factor_s2_reg <= factor_s1_reg;
            src_s2_reg    <= src_s1_reg;
        end
        if (en.st3) begin
            factor_s3_reg <= factor_s2_reg;
            src_s3_reg    <= src_s2_reg;
        end
    end

    // Four identical lanes. The blend in stage three reads the factors of
    // stage two's register, and the final register in stage four reads the
    // bypass flag and source of stage three's register, so both line up
    // with the lane data.
    //
    // The alpha lane enters with a colour of 255: since 255*0x8081 is
    // 2^23+127, the premultiply then returns the alpha itself, so alpha goes
    // through the same lane hardware as the colours.
    pdc_lane u_lane_red (
        .aclk         (aclk),
        .en           (en),
        .src_color    (s_src_red),
        .src_alpha    (s_src_alpha),
        .dst_color    (s_dst_red),
        .dst_alpha    (s_dst_alpha),
        .fa           (factor_s2_reg.fa),
        .fb           (factor_s2_reg.fb),
        .bypass       (factor_s3_reg.bypass),
        .bypass_value (src_s3_reg[7:0]),
        .result       (m_out_red)
    );

    pdc_lane u_lane_green (
        .aclk         (aclk),
        .en           (en),
        .src_color    (s_src_green),
        .src_alpha    (s_src_alpha),
        .dst_color    (s_dst_green),
        .dst_alpha    (s_dst_alpha),
        .fa           (factor_s2_reg.fa),
        .fb           (factor_s2_reg.fb),
        .bypass       (factor_s3_reg.bypass),
        .bypass_value (src_s3_reg[15:8]),
        .result       (m_out_green)
    );

    pdc_lane u_lane_blue (
        .aclk         (aclk),
        .en           (en),
        .src_color    (s_src_blue),
        .src_alpha    (s_src_alpha),
        .dst_color    (s_dst_blue),
        .dst_alpha    (s_dst_alpha),
        .fa           (factor_s2_reg.fa),
        .fb           (factor_s2_reg.fb),
        .bypass       (factor_s3_reg.bypass),
        .bypass_value (src_s3_reg[23:16]),
        .result       (m_out_blue)
    );

    pdc_lane u_lane_alpha (
        .aclk         (aclk),
        .en           (en),
        .src_color    (pdc_pkg::FULL),
        .src_alpha    (s_src_alpha),
        .dst_color    (pdc_pkg::FULL),
        .dst_alpha    (s_dst_alpha),
        .fa           (factor_s2_reg.fa),
        .fb           (factor_s2_reg.fb),
        .bypass       (factor_s3_reg.bypass),
        .bypass_value (src_s3_reg[31:24]),
        .result       (m_out_alpha)
    );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for porter_duff_rgba8_compositor_core.
// It drives source/destination pixel words through every compositing rule and
// checks each result word against a built-in predictor. Needs pdc_pkg and the core.
module tb;
    import pdc_pkg::*;

    // Rule codes 14 and 15 are not in the enum. The block must treat them as clear.
    localparam logic [3:0] RULE_SPARE_LO = 4'd14;
    localparam logic [3:0] RULE_SPARE_HI = 4'd15;

    // Cycles without any accepted word before the run is declared hung.
    localparam int QUIET_LIMIT = 4000;
    // Extra cycles after the last result word, to let the pipeline settle.
    localparam int SETTLE_CYCLES = 8;
    localparam int PIXELS_PER_RULE = 29;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } rgba_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic [3:0] cfg_wdata = RULE_RESET;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_src_red = '0, s_src_green = '0, s_src_blue = '0, s_src_alpha = '0;
    logic [7:0] s_dst_red = '0, s_dst_green = '0, s_dst_blue = '0, s_dst_alpha = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_red, m_out_green, m_out_blue, m_out_alpha;

    // Pacing knobs. Each random phase sets them in percent.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // The results that the block still owes, oldest first.
    rgba_t      composited_due[$];
    // A copy of the rule register. It follows the writes that the block sees.
    logic [3:0] tracked_rule = RULE_RESET;
    int         mismatches = 0;
    int         pixels_sent = 0;
    int         quiet_cycles = 0;
    logic [15:0] rules_hit = '0;

    porter_duff_rgba8_compositor_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_src_red   (s_src_red),
        .s_src_green (s_src_green),
        .s_src_blue  (s_src_blue),
        .s_src_alpha (s_src_alpha),
        .s_dst_red   (s_dst_red),
        .s_dst_green (s_dst_green),
        .s_dst_blue  (s_dst_blue),
        .s_dst_alpha (s_dst_alpha),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_red   (m_out_red),
        .m_out_green (m_out_green),
        .m_out_blue  (m_out_blue),
        .m_out_alpha (m_out_alpha)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Fixed-point divide by 255, the way the block rounds it.
    function automatic logic [8:0] by_255(logic [15:0] x);
        logic [31:0] prod;
        prod = 32'(x) * 32'(MAGIC_MUL);
        return 9'(prod >> MAGIC_SHIFT);
    endfunction

    // Weighted sum of two terms. The sum is clamped to 16 bits and the
    // quotient is clamped to one byte.
    function automatic logic [7:0] blend_term(logic [7:0] fa, logic [7:0] ps,
                                              logic [7:0] fb, logic [7:0] pd);
        logic [31:0] sum;
        logic [8:0]  q;
        sum = 32'(fa) * 32'(ps) + 32'(fb) * 32'(pd);
        if (sum > 32'hFFFF) begin
            sum = 32'hFFFF;
        end
        q = by_255(sum[15:0]);
        return (q > 9'(FULL)) ? FULL : q[7:0];
    endfunction

    // Predicts the composited pixel for one source/destination pair.
    function automatic rgba_t composite_pixel(logic [3:0] rule, rgba_t src, rgba_t dst);
        logic [7:0] fa;
        logic [7:0] fb;
        rgba_t      res;
        fa = '0;
        fb = '0;
        // Bypass returns the straight source pixel without premultiplying it.
        if (rule == RULE_BYPASS) begin
            return src;
        end
        case (rule)
            RULE_COPY: begin
                fa = FULL;
            end
            RULE_DEST: begin
                fb = FULL;
            end
            RULE_SRC_OVER: begin
                fa = FULL;
                fb = FULL - src.alpha;
            end
            RULE_DEST_OVER: begin
                fa = FULL - dst.alpha;
                fb = FULL;
            end
            RULE_SRC_IN: begin
                fa = dst.alpha;
            end
            RULE_DEST_IN: begin
                fb = src.alpha;
            end
            RULE_SRC_OUT: begin
                fa = FULL - dst.alpha;
            end
            RULE_DEST_OUT: begin
                fb = FULL - src.alpha;
            end
            RULE_SRC_ATOP: begin
                fa = dst.alpha;
                fb = FULL - src.alpha;
            end
            RULE_DEST_ATOP: begin
                fa = FULL - dst.alpha;
                fb = src.alpha;
            end
            RULE_XOR: begin
                fa = FULL - dst.alpha;
                fb = FULL - src.alpha;
            end
            RULE_LIGHTER: begin
                fa = FULL;
                fb = FULL;
            end
            // Clear and the two spare codes leave both factors at zero.
            default: begin
            end
        endcase
        res.red   = blend_term(fa, 8'(by_255(16'(src.red) * 16'(src.alpha))),
                               fb, 8'(by_255(16'(dst.red) * 16'(dst.alpha))));
        res.green = blend_term(fa, 8'(by_255(16'(src.green) * 16'(src.alpha))),
                               fb, 8'(by_255(16'(dst.green) * 16'(dst.alpha))));
        res.blue  = blend_term(fa, 8'(by_255(16'(src.blue) * 16'(src.alpha))),
                               fb, 8'(by_255(16'(dst.blue) * 16'(dst.alpha))));
        res.alpha = blend_term(fa, src.alpha, fb, dst.alpha);
        return res;
    endfunction

    task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // Scoreboard. The result word is checked before the input word of the same
    // edge is predicted. A result word can never belong to an input word of the
    // same edge, and this order stops a stray result from taking a fresh
    // expectation. The rule copy is updated last, so the input word of a write
    // edge still uses the old rule, as the block does.
    always @(posedge aclk) begin
        rgba_t want;
        if (!aresetn) begin
            tracked_rule = RULE_RESET;
        end else begin
            if (m_valid && m_ready) begin
                if (composited_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result word with no pixel outstanding, got %h",
                             $time, {m_out_red, m_out_green, m_out_blue, m_out_alpha});
                end else begin
                    want = composited_due.pop_front();
                    check_field("out_red", want.red, m_out_red);
                    check_field("out_green", want.green, m_out_green);
                    check_field("out_blue", want.blue, m_out_blue);
                    check_field("out_alpha", want.alpha, m_out_alpha);
                end
            end
            if (s_valid && s_ready) begin
                composited_due.push_back(composite_pixel(tracked_rule,
                    {s_src_red, s_src_green, s_src_blue, s_src_alpha},
                    {s_dst_red, s_dst_green, s_dst_blue, s_dst_alpha}));
                pixels_sent++;
            end
            if (cfg_we) begin
                tracked_rule = cfg_wdata;
            end
        end
    end

    // The receiver stalls at random at the rate of the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog. A hung handshake stops the run instead of letting it spin forever.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no word accepted for %0d cycles, %0d results outstanding",
                         $time, QUIET_LIMIT, composited_due.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Sends one pixel pair. The task may idle first, and it returns on the edge
    // at which the word is accepted. Valid stays high, so back-to-back words do
    // not leave a bubble.
    task automatic send_pixel(rgba_t src, rgba_t dst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_src_red   <= src.red;
        s_src_green <= src.green;
        s_src_blue  <= src.blue;
        s_src_alpha <= src.alpha;
        s_dst_red   <= dst.red;
        s_dst_green <= dst.green;
        s_dst_blue  <= dst.blue;
        s_dst_alpha <= dst.alpha;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    // Drops valid and waits until every result has come back. It then lets the
    // pipeline settle.
    task automatic wait_until_drained();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (composited_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes the rule register. It is called only while the block is idle.
    task automatic apply_rule(logic [3:0] code);
        cfg_we    <= 1'b1;
        cfg_wdata <= code;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        rules_hit[code] = 1'b1;
    endtask

    // Edge values come up more often, so that opaque, transparent and
    // saturating cases happen in the random traffic.
    function automatic logic [7:0] random_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic rgba_t random_rgba();
        return {random_byte(), random_byte(), random_byte(), random_byte()};
    endfunction

    // The rule register must come out of reset as src_over.
    task automatic test_reset_rule();
        send_pixel({8'hFF, 8'h80, 8'h01, 8'h80}, {8'h20, 8'hC0, 8'hFF, 8'hFF});
        send_pixel({8'h40, 8'h40, 8'h40, 8'hFF}, {8'hFF, 8'h00, 8'h99, 8'h33});
        send_pixel({8'h7F, 8'hFE, 8'h02, 8'h00}, {8'h11, 8'h22, 8'h33, 8'h44});
        rules_hit[RULE_SRC_OVER] = 1'b1;
        wait_until_drained();
    endtask

    // Each code once on one mixed pixel: bypass, all thirteen rules and the
    // two spare codes.
    task automatic test_each_rule();
        for (int code = RULE_BYPASS; code <= RULE_SPARE_HI; code++) begin
            apply_rule(4'(code));
            send_pixel({8'hFF, 8'h80, 8'h01, 8'hC8}, {8'h00, 8'h4D, 8'hFF, 8'h5A});
            wait_until_drained();
        end
    endtask

    // Extreme values. Lighter on full pixels saturates both the 16-bit sum and
    // the quotient. A fully transparent source under src_over must leave the
    // destination.
    task automatic test_extremes();
        apply_rule(RULE_LIGHTER);
        send_pixel('0, '0);
        send_pixel('1, '1);
        send_pixel({4{8'hAA}}, {4{8'h55}});
        send_pixel({4{8'h55}}, {4{8'hAA}});
        wait_until_drained();
        apply_rule(RULE_SRC_OVER);
        send_pixel({8'hFF, 8'hFF, 8'hFF, 8'h00}, {8'h10, 8'h20, 8'h30, 8'hFF});
        send_pixel({8'h12, 8'h34, 8'h56, 8'hFF}, {8'hFF, 8'hFF, 8'hFF, 8'hFF});
        wait_until_drained();
    endtask

    // Random pixels under every code. The codes start at a random point, and
    // the pacing is set by the arguments.
    task automatic test_random_pixels(int idle_pct, int stall_pct);
        logic [3:0] first_rule;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        first_rule     = 4'($urandom_range(15));
        for (int seg = 0; seg < 16; seg++) begin
            apply_rule(first_rule + 4'(seg));
            repeat (PIXELS_PER_RULE) send_pixel(random_rgba(), random_rgba());
            wait_until_drained();
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_rule();
        test_each_rule();
        test_extremes();
        test_random_pixels(0, 0);
        test_random_pixels(63, 0);
        test_random_pixels(0, 63);
        test_random_pixels(33, 33);

        $display("Composited %0d pixel pairs under %0d rule codes, with four pacing mixes",
                 pixels_sent, $countones(rules_hit));
        $display("on the input and result sides, and found %0d field mismatches.", mismatches);
        if (mismatches == 0 && composited_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== porter_duff_rgba8_compositor_core.f =====
rtl/pdc_pkg.sv
rtl/pdc_factor.sv
rtl/pdc_lane.sv
rtl/porter_duff_rgba8_compositor_core.sv
verif/tb.sv
